// ===== hdl/hwcm_pkg.sv =====
// ----------------------------------------------------------------------------
// hwcm_pkg
// Shared constants, types and width helpers for the horizontal window
// contrast map.
// ----------------------------------------------------------------------------
package hwcm_pkg;

    localparam int PIX_W          = 8;
    localparam int CHANNELS       = 3;
    localparam int PIXEL_W        = CHANNELS * PIX_W;
    localparam int COL_W          = 10;
    localparam int ENERGY_W       = 28;
    localparam int ROW_WIDTH_W    = 11;
    localparam int WINDOW_W       = 6;
    localparam int MAX_WINDOW_DEF = 32;
    localparam int MAX_ROW_WIDTH  = 1024;
    localparam int LANE_TAPS      = 8;
    localparam int LANE_SUM_W     = PIX_W + $clog2(LANE_TAPS);
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 11'd376;
    localparam logic [WINDOW_W-1:0]    WINDOW_RST    = 6'd5;
    localparam logic [ENERGY_W-1:0]    ENERGY_ONES   = '1;

    typedef enum logic [0:0] {
        REG_ROW_WIDTH   = 1'b0,
        REG_WINDOW_SIZE = 1'b1
    } t_reg_idx;

    // load enables for the two merge stages
    typedef struct packed {
        logic load_sum;
        logic load_sq;
    } t_merge_ctl;

    // bits of one window sum for the given largest half window
    function automatic int sum_width(input int max_window);
        return PIX_W + $clog2(max_window + 1);
    endfunction

    // lanes needed to cover both half windows
    function automatic int lane_count(input int max_window);
        return (2 * max_window + LANE_TAPS - 1) / LANE_TAPS;
    endfunction

endpackage

// ===== hdl/hwcm_if.sv =====
// ----------------------------------------------------------------------------
// hwcm channel interfaces
// Valid/ready channels for pixel words in and energy words out.
// ----------------------------------------------------------------------------
interface hwcm_pix_if;
    import hwcm_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             first_of_frame;

    modport source (output valid, red, green, blue, first_of_frame, input ready);
    modport sink   (input valid, red, green, blue, first_of_frame, output ready);
endinterface

interface hwcm_res_if;
    import hwcm_pkg::*;

    logic                valid;
    logic                ready;
    logic [COL_W-1:0]    column;
    logic [COL_W-1:0]    row;
    logic [ENERGY_W-1:0] energy;
    logic [ENERGY_W-1:0] frame_min;
    logic [ENERGY_W-1:0] frame_max;

    modport source (output valid, column, row, energy, frame_min, frame_max, input ready);
    modport sink   (input valid, column, row, energy, frame_min, frame_max, output ready);
endinterface

// ===== hdl/hwcm_lane.sv =====
// ----------------------------------------------------------------------------
// hwcm_lane
// Sums one group of delay taps per channel under the near and full masks.
// ----------------------------------------------------------------------------
module hwcm_lane (
    input  logic                                                          i_clk,
    input  logic                                                          i_load,
    input  logic [hwcm_pkg::LANE_TAPS-1:0][hwcm_pkg::PIXEL_W-1:0]         i_taps,
    input  logic [hwcm_pkg::LANE_TAPS-1:0]                                i_near,
    input  logic [hwcm_pkg::LANE_TAPS-1:0]                                i_all,
    output logic [hwcm_pkg::CHANNELS-1:0][hwcm_pkg::LANE_SUM_W-1:0]       o_near,
    output logic [hwcm_pkg::CHANNELS-1:0][hwcm_pkg::LANE_SUM_W-1:0]       o_all
);
    import hwcm_pkg::*;

    logic [CHANNELS-1:0][LANE_SUM_W-1:0] n_near;
    logic [CHANNELS-1:0][LANE_SUM_W-1:0] n_all;
    logic [CHANNELS-1:0][LANE_SUM_W-1:0] r_near;
    logic [CHANNELS-1:0][LANE_SUM_W-1:0] r_all;

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            n_near[ch] = '0;
            n_all[ch]  = '0;
            for (int k = 0; k < LANE_TAPS; k++) begin
                if (i_near[k]) begin
                    n_near[ch] = n_near[ch] + LANE_SUM_W'(i_taps[k][ch*PIX_W +: PIX_W]);
                end
                if (i_all[k]) begin
                    n_all[ch] = n_all[ch] + LANE_SUM_W'(i_taps[k][ch*PIX_W +: PIX_W]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_near <= n_near;
            r_all  <= n_all;
        end
    end

    assign o_near = r_near;
    assign o_all  = r_all;

endmodule

// ===== hdl/hwcm_merge.sv =====
// ----------------------------------------------------------------------------
// hwcm_merge
// Combines lane sums into left/right window sums, then squares their
// difference per channel.
// ----------------------------------------------------------------------------
module hwcm_merge #(
    parameter int MAX_WINDOW = hwcm_pkg::MAX_WINDOW_DEF
) (
    input  logic                                   i_clk,
    input  hwcm_pkg::t_merge_ctl                   i_ctl,
    input  logic [hwcm_pkg::lane_count(MAX_WINDOW)-1:0]
                 [hwcm_pkg::CHANNELS-1:0][hwcm_pkg::LANE_SUM_W-1:0] i_near,
    input  logic [hwcm_pkg::lane_count(MAX_WINDOW)-1:0]
                 [hwcm_pkg::CHANNELS-1:0][hwcm_pkg::LANE_SUM_W-1:0] i_all,
    output logic [hwcm_pkg::CHANNELS-1:0][2*hwcm_pkg::sum_width(MAX_WINDOW)-1:0] o_sq
);
    import hwcm_pkg::*;

    localparam int N_LANES = lane_count(MAX_WINDOW);
    localparam int SUM_W   = sum_width(MAX_WINDOW);
    localparam int SQ_W    = 2 * SUM_W;

    logic [CHANNELS-1:0][SUM_W-1:0] n_right;
    logic [CHANNELS-1:0][SUM_W:0]   n_both;
    logic [CHANNELS-1:0][SUM_W-1:0] r_right;
    logic [CHANNELS-1:0][SUM_W-1:0] r_left;
    logic [CHANNELS-1:0][SUM_W-1:0] diff;
    logic [CHANNELS-1:0][SQ_W-1:0]  r_sq;

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            n_right[ch] = '0;
            n_both[ch]  = '0;
            for (int l = 0; l < N_LANES; l++) begin
                n_right[ch] = n_right[ch] + SUM_W'(i_near[l][ch]);
                n_both[ch]  = n_both[ch] + (SUM_W+1)'(i_all[l][ch]);
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            diff[ch] = (r_left[ch] > r_right[ch]) ? r_left[ch] - r_right[ch]
                                                  : r_right[ch] - r_left[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sum) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_right[ch] <= n_right[ch];
                // full span minus near half leaves the left half
                r_left[ch]  <= SUM_W'(n_both[ch] - (SUM_W+1)'(n_right[ch]));
            end
        end
        if (i_ctl.load_sq) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_sq[ch] <= SQ_W'(diff[ch]) * SQ_W'(diff[ch]);
            end
        end
    end

    assign o_sq = r_sq;

endmodule

// ===== hdl/horizontal_window_contrast_map.sv =====
// After its pixel is taken, a result word passes the lane, sum, square and output registers.
// Throughput: one pixel word per clock; the pipeline stalls only when the sink holds
//   ready low and every stage between input and output is full.
// Reset (synchronous, active low): clears counters, pipeline valids and min/max,
//   and loads row_width 376 and window_size 5; the pixel delay line is not cleared.
// ----------------------------------------------------------------------------
// horizontal_window_contrast_map
// Horizontal gradient energy of two adjacent box windows over an RGB raster
// stream, with the running minimum and maximum energy of the frame.
// ----------------------------------------------------------------------------
module horizontal_window_contrast_map #(
    parameter int MAX_WINDOW = hwcm_pkg::MAX_WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    hwcm_pix_if.sink                            i_pix,
    hwcm_res_if.source                          o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hwcm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hwcm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hwcm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import hwcm_pkg::*;

    // Pipeline:
    //   accept : count columns/rows, shift the pixel into the delay line,
    //            build tap masks from the window size
    //   stage 1: lanes sum eight taps each, per channel, for both masks
    //   stage 2: merge adds the lanes into right and left window sums
    //   stage 3: merge squares the left-minus-right difference per channel
    //   stage 4: add the channels, update frame min/max, hold the result word
    // Each stage moves on when the stage after it is empty or moving, so
    // bubbles collapse and pixels keep flowing while a result word waits.

    localparam int DEPTH     = 2 * MAX_WINDOW;
    localparam int N_LANES   = lane_count(MAX_WINDOW);
    localparam int TAPS      = N_LANES * LANE_TAPS;
    localparam int SUM_W     = sum_width(MAX_WINDOW);
    localparam int SQ_W      = 2 * SUM_W;
    localparam int EFULL_W   = (SQ_W + 2 > ENERGY_W) ? SQ_W + 2 : ENERGY_W;
    localparam int CW        = COL_W + 2;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [COL_W-1:0] row;
        logic             fresh;
    } t_tag;

    // ---------------- configuration registers ----------------
    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic [WINDOW_W-1:0]    r_window;
    logic                   cfg_wr;
    t_reg_idx               cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_ADDR_W-1]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_window    <= WINDOW_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ROW_WIDTH:   r_row_width <= pwdata[ROW_WIDTH_W-1:0];
                REG_WINDOW_SIZE: r_window    <= pwdata[WINDOW_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ROW_WIDTH:   prdata = APB_DATA_W'(r_row_width);
            REG_WINDOW_SIZE: prdata = APB_DATA_W'(r_window);
        endcase
    end

    // Clamp the window to 1..MAX_WINDOW and the row width to 1..MAX_ROW_WIDTH.
    logic [CW-1:0]          win_raw;
    logic [CW-1:0]          w_c;
    logic [ROW_WIDTH_W-1:0] width_eff;

    assign win_raw = CW'(r_window);

    always_comb begin
        if (win_raw == '0) begin
            w_c = CW'(1);
        end else if (win_raw > CW'(MAX_WINDOW)) begin
            w_c = CW'(MAX_WINDOW);
        end else begin
            w_c = win_raw;
        end
        if (r_row_width == '0) begin
            width_eff = ROW_WIDTH_W'(1);
        end else if (r_row_width > ROW_WIDTH_W'(MAX_ROW_WIDTH)) begin
            width_eff = ROW_WIDTH_W'(MAX_ROW_WIDTH);
        end else begin
            width_eff = r_row_width;
        end
    end

    // ---------------- flow control ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;
    logic acc;

    assign en4         = !r_v4 || o_res.ready;
    assign en3         = !r_v3 || en4;
    assign en2         = !r_v2 || en3;
    assign en1         = !r_v1 || en2;
    assign i_pix.ready = en1;
    assign acc         = i_pix.valid && en1;

    // ---------------- column/row counting ----------------
    logic [COL_W-1:0]       r_col;
    logic [COL_W-1:0]       r_row;
    logic                   r_fresh;
    logic [COL_W-1:0]       cur_col;
    logic [COL_W-1:0]       cur_row;
    logic [ROW_WIDTH_W-1:0] col_p1;
    logic                   row_end;
    logic                   emit;
    t_tag                   tag0;

    // Frame start restarts both counters before this pixel is placed.
    assign cur_col = i_pix.first_of_frame ? '0 : r_col;
    assign cur_row = i_pix.first_of_frame ? '0 : r_row;
    assign col_p1  = ROW_WIDTH_W'(cur_col) + ROW_WIDTH_W'(1);
    // Also ends the row when a width change left the counter past the end.
    assign row_end = col_p1 >= width_eff;
    assign emit    = (CW'(cur_col) >= (w_c << 1) - CW'(1)) && !row_end;

    assign tag0.column = cur_col + COL_W'(1) - COL_W'(w_c);
    assign tag0.row    = cur_row;
    assign tag0.fresh  = i_pix.first_of_frame || r_fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_fresh <= 1'b0;
        end else if (acc) begin
            r_col   <= row_end ? '0 : col_p1[COL_W-1:0];
            r_row   <= row_end ? cur_row + COL_W'(1) : cur_row;
            // Remember a frame start until its first result word carries it.
            r_fresh <= emit ? 1'b0 : tag0.fresh;
        end
    end

    // ---------------- delay line and lane taps ----------------
    logic [DEPTH-2:0][PIXEL_W-1:0]  r_line;
    logic [PIXEL_W-1:0]             pix_in;
    logic [TAPS-1:0][PIXEL_W-1:0]   taps;
    logic [TAPS-1:0]                mask_near;
    logic [TAPS-1:0]                mask_all;

    assign pix_in = {i_pix.blue, i_pix.green, i_pix.red};

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_line[0] <= pix_in;
            for (int i = 1; i < DEPTH - 1; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    // Tap 0 is the pixel being taken, tap k the pixel k columns back.
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            if (k == 0) begin
                taps[k] = pix_in;
            end else if (k < DEPTH) begin
                taps[k] = r_line[k-1];
            end else begin
                taps[k] = '0;
            end
            mask_near[k] = CW'(k) < w_c;
            mask_all[k]  = CW'(k) < (w_c << 1);
        end
    end

    logic [N_LANES-1:0][CHANNELS-1:0][LANE_SUM_W-1:0] lane_near;
    logic [N_LANES-1:0][CHANNELS-1:0][LANE_SUM_W-1:0] lane_all;

    for (genvar l = 0; l < N_LANES; l++) begin : g_lane
        hwcm_lane u_lane (
            .i_clk  (i_clk),
            .i_load (en1),
            .i_taps (taps[l*LANE_TAPS +: LANE_TAPS]),
            .i_near (mask_near[l*LANE_TAPS +: LANE_TAPS]),
            .i_all  (mask_all[l*LANE_TAPS +: LANE_TAPS]),
            .o_near (lane_near[l]),
            .o_all  (lane_all[l])
        );
    end

    // ---------------- merge and square ----------------
    t_merge_ctl                    merge_ctl;
    logic [CHANNELS-1:0][SQ_W-1:0] sq;

    assign merge_ctl.load_sum = en2;
    assign merge_ctl.load_sq  = en3;

    hwcm_merge #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_merge (
        .i_clk  (i_clk),
        .i_ctl  (merge_ctl),
        .i_near (lane_near),
        .i_all  (lane_all),
        .o_sq   (sq)
    );

    // ---------------- tag pipeline ----------------
    t_tag r_tag1, r_tag2, r_tag3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= acc && emit;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_tag1 <= tag0;
        end
        if (en2) begin
            r_tag2 <= r_tag1;
        end
        if (en3) begin
            r_tag3 <= r_tag2;
        end
    end

    // ---------------- energy, frame min/max, output word ----------------
    logic [EFULL_W-1:0]  energy_full;
    logic [ENERGY_W-1:0] energy;
    logic [ENERGY_W-1:0] base_min;
    logic [ENERGY_W-1:0] base_max;
    logic [ENERGY_W-1:0] n_emin;
    logic [ENERGY_W-1:0] n_emax;
    logic [ENERGY_W-1:0] r_emin;
    logic [ENERGY_W-1:0] r_emax;
    logic [COL_W-1:0]    r_out_col;
    logic [COL_W-1:0]    r_out_row;
    logic [ENERGY_W-1:0] r_out_energy;
    logic [ENERGY_W-1:0] r_out_min;
    logic [ENERGY_W-1:0] r_out_max;

    assign energy_full = EFULL_W'(sq[0]) + EFULL_W'(sq[1]) + EFULL_W'(sq[2]);
    assign energy      = energy_full[ENERGY_W-1:0];
    // The first word of a frame starts from the reset extremes.
    assign base_min    = r_tag3.fresh ? ENERGY_ONES : r_emin;
    assign base_max    = r_tag3.fresh ? '0 : r_emax;
    assign n_emin      = (energy < base_min) ? energy : base_min;
    assign n_emax      = (energy > base_max) ? energy : base_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4   <= 1'b0;
            r_emin <= ENERGY_ONES;
            r_emax <= '0;
        end else if (en4) begin
            r_v4 <= r_v3;
            if (r_v3) begin
                r_emin <= n_emin;
                r_emax <= n_emax;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_v3) begin
            r_out_col    <= r_tag3.column;
            r_out_row    <= r_tag3.row;
            r_out_energy <= energy;
            r_out_min    <= n_emin;
            r_out_max    <= n_emax;
        end
    end

    assign o_res.valid     = r_v4;
    assign o_res.column    = r_out_col;
    assign o_res.row       = r_out_row;
    assign o_res.energy    = r_out_energy;
    assign o_res.frame_min = r_out_min;
    assign o_res.frame_max = r_out_max;

`ifndef SYNTHESIS
    // A shown word always lies inside the frame extremes it reports.
    a_minmax_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_out_min <= r_out_energy) && (r_out_energy <= r_out_max))
        else $error("energy outside reported frame min/max");

    // An emitting pixel must occupy the lane stage on the next cycle.
    a_emit_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && emit) |=> r_v1)
        else $error("emitting pixel lost at lane stage");

    // An empty lane stage never holds off the pixel source.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> i_pix.ready)
        else $error("input stalled with empty lane stage");
`endif

endmodule

// ===== test/horizontal_window_contrast_map_test.sv =====
// ----------------------------------------------------------------------------
// horizontal_window_contrast_map_test
// Self-checking bench for the horizontal window contrast map. Pixel words go
// in on a valid/ready channel with random bursts and gaps. Energy words are
// drained through a sink that stalls in changing patterns. A local model of
// the window sums, counters and frame min/max predicts every energy word,
// and each one is compared field by field in arrival order. The registers are
// written and read back over APB only while the pipeline is empty.
// ----------------------------------------------------------------------------
module horizontal_window_contrast_map_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hwcm_pkg::*;

    localparam int HISTORY_DEPTH  = 2 * MAX_WINDOW_DEF;
    localparam int SETTLE_CYCLES  = 8;     // pipeline is 4 deep
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS  = 800;

    typedef struct {
        logic [COL_W-1:0]    column;
        logic [COL_W-1:0]    row;
        logic [ENERGY_W-1:0] energy;
        logic [ENERGY_W-1:0] frame_low;
        logic [ENERGY_W-1:0] frame_high;
    } t_contrast;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_BURSTY, SINK_THIRDS} t_sink_mode;
    typedef enum {ROW_NOISE, ROW_STEP, ROW_FLAT} t_row_style;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hwcm_pix_if pixel_bus ();
    hwcm_res_if energy_bus ();

    horizontal_window_contrast_map DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pixel_bus),
        .o_res   (energy_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Contrast predictor state: register shadows, the pixel history of the
    // current row, the raster counters and the frame extremes.
    // ------------------------------------------------------------------------
    logic [ROW_WIDTH_W-1:0] width_reg  = ROW_WIDTH_RST;
    logic [WINDOW_W-1:0]    window_reg = WINDOW_RST;
    logic [PIXEL_W-1:0]     pixel_history [HISTORY_DEPTH];
    logic [COL_W-1:0]       next_column = '0;
    logic [COL_W-1:0]       next_row    = '0;
    logic [ENERGY_W-1:0]    frame_low   = ENERGY_ONES;
    logic [ENERGY_W-1:0]    frame_high  = '0;

    t_contrast   pending_energy_q [$];
    int unsigned pixels_sent    = 0;
    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;
    int unsigned quiet_cycles   = 0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Count one mismatch and print it on one line.
    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Advance the predictor by one accepted pixel word and queue the energy
    // word it causes, if any.
    function automatic void predict_contrast(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic fof);
        int unsigned win;
        int unsigned span;
        int unsigned c;
        int unsigned left_sum;
        int unsigned right_sum;
        int unsigned diff;
        int unsigned energy;
        t_contrast   want;

        // clamp the registers the way the block does
        win  = window_reg;
        span = width_reg;
        if (win < 1) win = 1;
        if (win > MAX_WINDOW_DEF) win = MAX_WINDOW_DEF;
        if (span < 1) span = 1;
        if (span > MAX_ROW_WIDTH) span = MAX_ROW_WIDTH;

        // frame start: restart the raster and the extremes before taking the pixel
        if (fof) begin
            next_column = '0;
            next_row    = '0;
            frame_low   = ENERGY_ONES;
            frame_high  = '0;
        end

        c = next_column;
        pixel_history[c % HISTORY_DEPTH] = {b, g, r};

        // the right half window ends at this pixel; the centre is c-win+1
        if (c >= 2 * win - 1 && c + 1 < span) begin
            energy = 0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                left_sum  = 0;
                right_sum = 0;
                for (int k = 0; k < win; k++) begin
                    right_sum += pixel_history[(c + HISTORY_DEPTH - k) % HISTORY_DEPTH]
                                              [PIX_W*ch +: PIX_W];
                    left_sum  += pixel_history[(c + HISTORY_DEPTH - win - k) % HISTORY_DEPTH]
                                              [PIX_W*ch +: PIX_W];
                end
                diff = (left_sum > right_sum) ? left_sum - right_sum : right_sum - left_sum;
                energy += diff * diff;
            end
            energy = energy & ENERGY_ONES;
            if (energy < frame_low) frame_low = energy;
            if (energy > frame_high) frame_high = energy;
            want.column     = COL_W'(c - win + 1);
            want.row        = next_row;
            want.energy     = ENERGY_W'(energy);
            want.frame_low  = frame_low;
            want.frame_high = frame_high;
            pending_energy_q.push_back(want);
        end

        // the row ends on its last column, or at once if the width shrank under us
        if (c + 1 >= span) begin
            next_column = '0;
            next_row    = next_row + 1'b1;
        end else begin
            next_column = COL_W'(c + 1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Pixel source: bursts of random length, random gaps between them.
    // valid stays high from one word to the next inside a burst.
    // ------------------------------------------------------------------------
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic fof);
        int unsigned gap;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                pixel_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;

        pixel_bus.valid          <= 1'b1;
        pixel_bus.red            <= r;
        pixel_bus.green          <= g;
        pixel_bus.blue           <= b;
        pixel_bus.first_of_frame <= fof;
        do @(posedge i_clk); while (pixel_bus.ready !== 1'b1);

        predict_contrast(r, g, b, fof);
        pixels_sent++;
    endtask

    // Drop valid and hold until every predicted energy word has come out.
    task automatic wait_until_drained();
        pixel_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_energy_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // APB access. The transfer returns at the completing edge with psel still
    // high, so a second transfer can follow back to back.
    // ------------------------------------------------------------------------
    task automatic apb_transfer(input logic is_write, input t_reg_idx idx,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
    endtask

    // Read a register back and compare it against its shadow.
    task automatic read_reg(input t_reg_idx idx);
        logic [APB_DATA_W-1:0] got;
        logic [APB_DATA_W-1:0] want;

        apb_transfer(1'b0, idx, '0, got);
        psel    <= 1'b0;
        penable <= 1'b0;
        want = (idx == REG_ROW_WIDTH) ? APB_DATA_W'(width_reg) : APB_DATA_W'(window_reg);
        if (got !== want) begin
            flag_mismatch($sformatf("%s read back %0d want %0d", idx.name(), got, want));
        end
    endtask

    // Write a register with the pipeline empty, then read it back.
    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        logic [APB_DATA_W-1:0] unused;

        wait_until_drained();
        // words that cause no energy may still be in flight; let them clear
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        apb_transfer(1'b1, idx, APB_DATA_W'(value), unused);
        if (idx == REG_ROW_WIDTH) begin
            width_reg = value[ROW_WIDTH_W-1:0];
        end else begin
            window_reg = value[WINDOW_W-1:0];
        end
        read_reg(idx);
    endtask

    // ------------------------------------------------------------------------
    // Energy sink: ready follows a mode that is redrawn at random after a span of random length,
    // from always open to long stalls.
    // ------------------------------------------------------------------------
    initial begin
        t_sink_mode  mode;
        int unsigned span;
        int unsigned stall_left;

        energy_bus.ready <= 1'b0;
        stall_left = 0;
        forever begin
            mode = t_sink_mode'($urandom_range(0, 3));
            span = $urandom_range(50, 300);
            for (int i = 0; i < span; i++) begin
                @(posedge i_clk);
                case (mode)
                    SINK_OPEN: begin
                        energy_bus.ready <= 1'b1;
                    end
                    SINK_COIN: begin
                        energy_bus.ready <= 1'($urandom_range(0, 1));
                    end
                    SINK_BURSTY: begin
                        if (stall_left != 0) begin
                            stall_left--;
                            energy_bus.ready <= 1'b0;
                        end else if ($urandom_range(0, 19) == 0) begin
                            stall_left = $urandom_range(5, 30);
                            energy_bus.ready <= 1'b0;
                        end else begin
                            energy_bus.ready <= 1'b1;
                        end
                    end
                    default: begin
                        energy_bus.ready <= (i % 3 == 0);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Energy checker: every accepted word against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_contrast want;

        if (i_rst_n && energy_bus.valid === 1'b1 && energy_bus.ready === 1'b1) begin
            if (pending_energy_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected word col %0d row %0d energy %0d",
                                        energy_bus.column, energy_bus.row,
                                        energy_bus.energy));
            end else begin
                want = pending_energy_q.pop_front();
                if (energy_bus.column !== want.column)
                    flag_mismatch($sformatf("column got %0d want %0d",
                                            energy_bus.column, want.column));
                if (energy_bus.row !== want.row)
                    flag_mismatch($sformatf("row got %0d want %0d (col %0d)",
                                            energy_bus.row, want.row, want.column));
                if (energy_bus.energy !== want.energy)
                    flag_mismatch($sformatf("energy got %0d want %0d (col %0d row %0d)",
                                            energy_bus.energy, want.energy,
                                            want.column, want.row));
                if (energy_bus.frame_min !== want.frame_low)
                    flag_mismatch($sformatf("frame_min got %0d want %0d (col %0d row %0d)",
                                            energy_bus.frame_min, want.frame_low,
                                            want.column, want.row));
                if (energy_bus.frame_max !== want.frame_high)
                    flag_mismatch($sformatf("frame_max got %0d want %0d (col %0d row %0d)",
                                            energy_bus.frame_max, want.frame_high,
                                            want.column, want.row));
            end
        end
    end

    // Watchdog: any handshake on any port counts as progress.
    always @(posedge i_clk) begin
        if ((pixel_bus.valid === 1'b1 && pixel_bus.ready === 1'b1) ||
            (energy_bus.valid === 1'b1 && energy_bus.ready === 1'b1) ||
            (psel && penable && pready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("horizontal_window_contrast_map_test: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // A rail half the time, otherwise anything.
    function automatic logic [7:0] draw_sample();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // The given rail three times in four, otherwise anything.
    function automatic logic [7:0] draw_level(input logic [7:0] rail);
        return ($urandom_range(0, 3) != 0) ? rail : 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    // Reset values of both registers, then one short frame at those settings:
    // width 376, window 5, so only the tenth pixel yields a word.
    task automatic test_reset_defaults();
        read_reg(REG_ROW_WIDTH);
        read_reg(REG_WINDOW_SIZE);
        for (int col = 0; col < 10; col++) begin
            send_pixel((col < 5) ? 8'hFF : 8'h00, (col < 5) ? 8'h00 : 8'hFF,
                       (col % 2) ? 8'hAA : 8'h55, col == 0);
        end
    endtask

    // Smallest row that yields a word (3) with the smallest window (1): one word per row,
    // every channel swinging between the rails.
    task automatic test_smallest_window();
        write_reg(REG_ROW_WIDTH, 3);
        write_reg(REG_WINDOW_SIZE, 1);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h5A, 8'hA5, 8'h3C, 1'b0);
    endtask

    // Rows too narrow for two half windows give nothing but still advance the
    // row count; zero width and zero window behave as one.
    task automatic test_narrow_rows();
        write_reg(REG_ROW_WIDTH, 4);
        write_reg(REG_WINDOW_SIZE, 2);
        for (int i = 0; i < 4; i++) begin
            send_pixel(draw_sample(), draw_sample(), draw_sample(), i == 0);
        end
        write_reg(REG_ROW_WIDTH, 0);
        write_reg(REG_WINDOW_SIZE, 0);
        for (int i = 0; i < 2; i++) begin
            send_pixel(draw_sample(), draw_sample(), draw_sample(), 1'b0);
        end
        // window 0 still acts as 1: one word, on row 3
        write_reg(REG_ROW_WIDTH, 3);
        for (int i = 0; i < 3; i++) begin
            send_pixel(draw_sample(), draw_sample(), draw_sample(), 1'b0);
        end
    endtask

    // Shrink the row mid-row so the column counter sits past the new last
    // column: the next pixel must close the row without a word.
    task automatic test_row_end_shrink();
        write_reg(REG_WINDOW_SIZE, 1);
        write_reg(REG_ROW_WIDTH, 8);
        for (int i = 0; i < 4; i++) begin
            send_pixel(draw_sample(), draw_sample(), draw_sample(), i == 0);
        end
        write_reg(REG_ROW_WIDTH, 3);
        for (int i = 0; i < 4; i++) begin
            send_pixel(draw_sample(), draw_sample(), draw_sample(), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Random frames: each one under a fresh setting, rows of noise, steps or
    // flat colour, with the odd stray frame start and drain pause.
    // ------------------------------------------------------------------------
    task automatic test_random_frames();
        int unsigned  stop_at;
        int unsigned  win_val;
        int unsigned  width_val;
        int unsigned  eff_win;
        int unsigned  eff_width;
        int unsigned  budget;
        int unsigned  col;
        int unsigned  step_col;
        logic         fof;
        logic [23:0]  hi_px;
        logic [23:0]  lo_px;
        logic [23:0]  px;
        t_row_style   style;

        stop_at = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0:       win_val = 0;
                1:       win_val = $urandom_range(MAX_WINDOW_DEF + 1, 63);
                2:       win_val = MAX_WINDOW_DEF;
                default: win_val = $urandom_range(1, 8);
            endcase
            eff_win = (win_val < 1) ? 1 : (win_val > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win_val;

            case ($urandom_range(0, 9))
                0: width_val = $urandom_range(0, 1) ? MAX_ROW_WIDTH
                                                    : $urandom_range(MAX_ROW_WIDTH + 1, 2047);
                1:       width_val = $urandom_range(0, 2 * eff_win);
                2:       width_val = 2 * eff_win + 1;
                default: width_val = 2 * eff_win + 1 + $urandom_range(0, 24);
            endcase
            eff_width = (width_val < 1) ? 1 :
                        (width_val > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : width_val;

            if (eff_width < 2 * eff_win + 1) begin
                budget = $urandom_range(10, 40);
            end else if (eff_win >= 16) begin
                budget = $urandom_range(130, 260);
            end else begin
                budget = $urandom_range(30, 120);
            end

            // the frame starts with a frame-start word, so the window may change here
            write_reg(REG_ROW_WIDTH, width_val);
            write_reg(REG_WINDOW_SIZE, win_val);

            style    = ROW_NOISE;
            step_col = 0;
            hi_px    = '0;
            lo_px    = '0;
            for (int n = 0; n < budget && pixels_sent < stop_at; n++) begin
                fof = (n == 0) || ($urandom_range(0, 199) == 0);
                col = fof ? 0 : next_column;
                if (col == 0) begin
                    style = t_row_style'($urandom_range(0, 2));
                    hi_px = {draw_level(8'hFF), draw_level(8'hFF), draw_level(8'hFF)};
                    lo_px = {draw_level(8'h00), draw_level(8'h00), draw_level(8'h00)};
                    // put the step on a centre column so the extreme energy shows up
                    if (eff_width >= 2 * eff_win + 1) begin
                        step_col = eff_win + $urandom_range(0, eff_width - 2 * eff_win - 1);
                    end else begin
                        step_col = $urandom_range(0, eff_width);
                    end
                    if ($urandom_range(0, 1)) begin
                        px    = hi_px;
                        hi_px = lo_px;
                        lo_px = px;
                    end
                end
                case (style)
                    ROW_STEP: px = (col < step_col) ? hi_px : lo_px;
                    ROW_FLAT: px = hi_px;
                    default:  px = {draw_sample(), draw_sample(), draw_sample()};
                endcase
                send_pixel(px[7:0], px[15:8], px[23:16], fof);
                // now and then hold the source until the pipeline runs dry
                if ($urandom_range(0, 249) == 0) begin
                    wait_until_drained();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n                  <= 1'b0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        pixel_bus.valid          <= 1'b0;
        pixel_bus.red            <= '0;
        pixel_bus.green          <= '0;
        pixel_bus.blue           <= '0;
        pixel_bus.first_of_frame <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_smallest_window();
        test_narrow_rows();
        test_row_end_shrink();
        test_random_frames();

        // drain, then give late strays a chance to show up
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("horizontal_window_contrast_map_test: PASS");
        end else begin
            $display("horizontal_window_contrast_map_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/hwcm_pkg.sv
hdl/hwcm_if.sv
hdl/hwcm_lane.sv
hdl/hwcm_merge.sv
hdl/horizontal_window_contrast_map.sv
test/horizontal_window_contrast_map_test.sv
